### design/hsv_to_rgb_converter_top_macros.svh
// Assertion helpers for the HSV to RGB converter.
`ifndef HSV_TO_RGB_CONVERTER_TOP_MACROS_SVH
`define HSV_TO_RGB_CONVERTER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check that cond holds at every clock edge outside reset.
`define HSV2RGB_ASSERT_HOLDS(label, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("hsv2rgb: invariant violated");

// Check that cause at one edge implies effect at the next edge.
`define HSV2RGB_ASSERT_NEXT(label, cause, effect) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cause) |=> (effect)) \
    else $error("hsv2rgb: sequence violated");

`else

`define HSV2RGB_ASSERT_HOLDS(label, cond)
`define HSV2RGB_ASSERT_NEXT(label, cause, effect)

`endif

`endif

### design/hsv2rgb_pkg.sv
package hsv2rgb_pkg;

  // Fixed point format of saturation, value and the channels
  localparam int unsigned ChanW    = 16;
  localparam int unsigned FracBits = 15;
  localparam logic [ChanW-1:0] One = ChanW'(1 << FracBits);

  // Hue geometry in 1/16 degree units
  localparam int unsigned SectorW   = 10;
  localparam logic [SectorW-1:0] HueSector = SectorW'(960);

  // Reciprocals of 15: floor(t/15) = (t * M) >> k over the ranges used here
  localparam logic [22:0] Div15Mul16 = 23'd4370;     // t < 2^10, k = 16
  localparam logic [19:0] Div15Mul23 = 20'd559241;   // t < 2^19, k = 23

  // Reciprocal of 6 for sector numbers below 128: (q * 43) >> 8
  localparam logic [12:0] Div6Mul = 13'd43;

  // Color wheel sectors
  typedef enum logic [2:0] {
    SecRed     = 3'd0,
    SecYellow  = 3'd1,
    SecGreen   = 3'd2,
    SecCyan    = 3'd3,
    SecBlue    = 3'd4,
    SecMagenta = 3'd5
  } sector_e;

endpackage

### design/hsv_to_rgb_converter_top.sv
// HSV to RGB pixel converter, five register stages.
// Throughput: one pixel per cycle; the whole pipeline halts while the output
//   holds a pixel that is not taken, so the rate is set by output tready.
// Reset: rst_ni clears all valid bits asynchronously; data registers are not reset.
`include "hsv_to_rgb_converter_top_macros.svh"

module hsv_to_rgb_converter_top import hsv2rgb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [47:0] s_axis_tdata_i,   // hue[15:0], saturation[31:16], brightness[47:32]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o    // red[15:0], green[31:16], blue[47:32]
);

  logic [4:0] vld_q;
  logic       adv;

  // Advance every stage when the output register is free or being taken
  assign adv             = !vld_q[4] || m_axis_tready_i;
  assign s_axis_tready_o = adv;
  assign m_axis_tvalid_o = vld_q[4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[3:0], s_axis_tvalid_i};
    end
  end

  // ---------------- Stage 1: clamp inputs, coarse sector number ----------------
  logic [ChanW-1:0] in_hue, in_sat, in_val;
  logic [22:0]      q_prod;
  logic [ChanW-1:0] s1_hue_q, s1_sat_q, s1_val_q;
  logic [ChanW-1:0] s1_sat_d, s1_val_d;
  logic [6:0]       s1_q_q, s1_q_d;

  assign in_hue = s_axis_tdata_i[15:0];
  assign in_sat = s_axis_tdata_i[31:16];
  assign in_val = s_axis_tdata_i[47:32];

  // hue / 960 = (hue >> 6) / 15
  assign q_prod   = {13'b0, in_hue[15:6]} * Div15Mul16;
  assign s1_q_d   = q_prod[22:16];
  assign s1_sat_d = (in_sat > One) ? One : in_sat;
  assign s1_val_d = (in_val > One) ? One : in_val;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_hue_q <= in_hue;
      s1_sat_q <= s1_sat_d;
      s1_val_q <= s1_val_d;
      s1_q_q   <= s1_q_d;
    end
  end

  // ---------------- Stage 2: sector, position, chroma ----------------
  logic [ChanW-1:0]   qx960, pos_full;
  logic [SectorW-1:0] pos;
  logic [12:0]        q6_prod;
  logic [4:0]         q6;
  logic [6:0]         sec_full;
  logic [31:0]        sv_prod;
  logic [2:0]         s2_sec_q, s2_sec_d;
  logic [SectorW-1:0] s2_w_q, s2_w_d;
  logic [ChanW-1:0]   s2_chroma_q, s2_chroma_d;
  logic [ChanW-1:0]   s2_val_q;

  assign qx960    = {9'b0, s1_q_q} * ChanW'(HueSector);
  assign pos_full = s1_hue_q - qx960;
  assign pos      = pos_full[SectorW-1:0];

  // Fold the coarse sector number onto the six-sector wheel
  assign q6_prod  = {6'b0, s1_q_q} * Div6Mul;
  assign q6       = q6_prod[12:8];
  assign sec_full = s1_q_q - ({2'b0, q6} * 7'd6);
  assign s2_sec_d = sec_full[2:0];

  // Odd sectors run backward
  assign s2_w_d      = s2_sec_d[0] ? (HueSector - pos) : pos;
  assign sv_prod     = s1_sat_q * s1_val_q;
  assign s2_chroma_d = sv_prod[FracBits +: ChanW];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_sec_q    <= s2_sec_d;
      s2_w_q      <= s2_w_d;
      s2_chroma_q <= s2_chroma_d;
      s2_val_q    <= s1_val_q;
    end
  end

  // ---------------- Stage 3: chroma * w, offset m ----------------
  logic [25:0]      s3_prod_q, s3_prod_d;
  logic [ChanW-1:0] s3_m_q, s3_m_d;
  logic [ChanW-1:0] s3_chroma_q;
  logic [2:0]       s3_sec_q;

  assign s3_prod_d = {10'b0, s2_chroma_q} * {16'b0, s2_w_q};
  assign s3_m_d    = s2_val_q - s2_chroma_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_prod_q   <= s3_prod_d;
      s3_m_q      <= s3_m_d;
      s3_chroma_q <= s2_chroma_q;
      s3_sec_q    <= s2_sec_q;
    end
  end

  // ---------------- Stage 4: x = prod / 960 ----------------
  logic [39:0]      x_prod;
  logic [ChanW-1:0] s4_x_q, s4_x_d;
  logic [ChanW-1:0] s4_m_q, s4_chroma_q;
  logic [2:0]       s4_sec_q;

  // prod / 960 = (prod >> 6) / 15
  assign x_prod = {20'b0, s3_prod_q[25:6]} * {20'b0, Div15Mul23};
  assign s4_x_d = x_prod[23 +: ChanW];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s4_x_q      <= s4_x_d;
      s4_m_q      <= s3_m_q;
      s4_chroma_q <= s3_chroma_q;
      s4_sec_q    <= s3_sec_q;
    end
  end

  // ---------------- Stage 5: sector assignment, add m ----------------
  logic [ChanW-1:0] r_pre, g_pre, b_pre;
  logic [ChanW-1:0] out_r_q, out_g_q, out_b_q;

  always_comb begin
    r_pre = '0;
    g_pre = '0;
    b_pre = '0;
    case (sector_e'(s4_sec_q))
      SecRed:    begin r_pre = s4_chroma_q; g_pre = s4_x_q;                            end
      SecYellow: begin r_pre = s4_x_q;      g_pre = s4_chroma_q;                       end
      SecGreen:  begin                      g_pre = s4_chroma_q; b_pre = s4_x_q;       end
      SecCyan:   begin                      g_pre = s4_x_q;      b_pre = s4_chroma_q;  end
      SecBlue:   begin r_pre = s4_x_q;                           b_pre = s4_chroma_q;  end
      default:   begin r_pre = s4_chroma_q;                      b_pre = s4_x_q;       end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_r_q <= r_pre + s4_m_q;
      out_g_q <= g_pre + s4_m_q;
      out_b_q <= b_pre + s4_m_q;
    end
  end

  assign m_axis_tdata_o = {out_b_q, out_g_q, out_r_q};

  // ---------------- Checks ----------------
  `HSV2RGB_ASSERT_HOLDS(a_chan_bound, !vld_q[4] || (out_r_q <= One && out_g_q <= One && out_b_q <= One))
  `HSV2RGB_ASSERT_HOLDS(a_x_below_chroma, !vld_q[3] || (s4_x_q <= s4_chroma_q))
  `HSV2RGB_ASSERT_NEXT(a_valid_travels, adv && vld_q[1], vld_q[2])

endmodule
